// ===== design/bap_pkg.sv =====
// Shared types and constants for the buddy page allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package bap_pkg;

    localparam int ACT_W     = 2;
    localparam int ORD_W     = 4;
    localparam int FRAME_W   = 20;
    localparam int CNT_W     = 11;
    localparam int ST_W      = 2;
    localparam int ABS_W     = 22;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_TOO_BIG = 2'd2;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME   = 2'd2;

    localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic              fit;
        logic [ORD_W-1:0]  k;
    } carve_step_t;

endpackage

`default_nettype wire

// ===== design/bap_mark_ram.sv =====
// Free-mark memory: one 32-bit word of marks per (order, row of pages).
// Depends on bap_pkg for the word width.
`default_nettype none

module bap_mark_ram #(
    parameter int AW    = 9,
    parameter int DEPTH = 512
) (
    input  wire logic                      clk,
    input  wire logic [AW-1:0]             raddr,
    output logic [bap_pkg::WORD_W-1:0]     rdata,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [bap_pkg::WORD_W-1:0] wdata
);

    logic [bap_pkg::WORD_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/bap_carve_step.sv =====
// Carve step: largest aligned block that starts at the cursor and fits below the limit.
// Depends on bap_pkg for widths and the step struct.
`default_nettype none

module bap_carve_step #(
    parameter int MAX_ORDER = 11
) (
    input  wire logic [bap_pkg::ABS_W-1:0] cur,
    input  wire logic [bap_pkg::ABS_W-1:0] lim,
    output bap_pkg::carve_step_t           step
);

    always_comb
    begin
        step.fit = (cur < lim);
        step.k   = '0;
        // alignment and fit are both monotone in k, so the last hit is the largest
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            if ((cur & ((bap_pkg::ABS_W'(1) << k) - bap_pkg::ABS_W'(1))) == '0 &&
                (cur + (bap_pkg::ABS_W'(1) << k)) <= lim)
            begin
                step.k = bap_pkg::ORD_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: control sequencer, counters, ports.
// Depends on bap_pkg, bap_mark_ram and bap_carve_step.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid/in_stall   | action, order, frame_in
//  out     | output    | out_valid/out_stall | status, frame_out, free_pages
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One item at a time: accepted in S_IDLE, dispatched in S_START, finished in S_FIN; between,
// init clears all 2^(ord bits + row bits) mark rows, then reads and writes once per carved
// block until none fits; alloc reads and checks each row scanned, then reads and writes per
// split; free reads and writes once, via the mark memory's single read-modify-write path.
// After reset the mark memory is swept clear of all those rows before in_stall drops.
// A finished beat waits in the output register; the next beat is taken meanwhile, and its
// finish cycle holds while the earlier beat is still stalled.
`default_nettype none

module buddy_page_allocator #(
    parameter int PAGES     = 1024,
    parameter int MAX_ORDER = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bap_pkg::ACT_W-1:0]     action,
    input  wire logic [bap_pkg::ORD_W-1:0]     order,
    input  wire logic [bap_pkg::FRAME_W-1:0]   frame_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bap_pkg::ST_W-1:0]           status,
    output logic [bap_pkg::FRAME_W-1:0]        frame_out,
    output logic [bap_pkg::CNT_W-1:0]          free_pages,
    input  wire logic                          cfg_we,
    input  wire logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bap_pkg::FRAME_W-1:0]   cfg_data
);

    localparam int ROWS  = (PAGES + bap_pkg::WORD_W - 1) / bap_pkg::WORD_W;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW    = RW + bap_pkg::BIT_W;
    localparam int OW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW    = OW + RW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_START    = 11'b00000000010,
        S_CLEAR    = 11'b00000000100,
        S_CARVE_RD = 11'b00000001000,
        S_CARVE_WR = 11'b00000010000,
        S_SCAN_RD  = 11'b00000100000,
        S_SCAN_CK  = 11'b00001000000,
        S_SPLIT_RD = 11'b00010000000,
        S_SPLIT_WR = 11'b00100000000,
        S_FREE_RD  = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [bap_pkg::ACT_W-1:0]       act_reg, act_next;
    logic [bap_pkg::ORD_W-1:0]       ord_reg, ord_next;
    logic [bap_pkg::FRAME_W-1:0]     fin_reg, fin_next;
    logic [bap_pkg::ORD_W-1:0]       j_reg, j_next;
    logic [RW-1:0]                   row_reg, row_next;
    logic [PW-1:0]                   wr_page_reg, wr_page_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic [bap_pkg::ABS_W-1:0]       cur_reg, cur_next;
    logic [AW-1:0]                   sweep_reg, sweep_next;
    logic                            carve_after_reg, carve_after_next;
    logic [bap_pkg::ST_W-1:0]        st_reg, st_next;
    logic [bap_pkg::FRAME_W-1:0]     fo_reg, fo_next;
    logic [bap_pkg::CNT_W-1:0]       total_reg, total_next;
    logic [bap_pkg::CNT_W-1:0]       cnt_reg [MAX_ORDER];
    logic [bap_pkg::CNT_W-1:0]       cnt_next [MAX_ORDER];
    logic                            out_valid_reg, out_valid_next;
    logic [bap_pkg::ST_W-1:0]        status_reg, status_next;
    logic [bap_pkg::FRAME_W-1:0]     frame_out_reg, frame_out_next;
    logic [bap_pkg::CNT_W-1:0]       free_pages_reg, free_pages_next;
    logic [bap_pkg::CNT_W-1:0]       page_count_reg, page_count_next;
    logic [bap_pkg::CNT_W-1:0]       first_usable_reg, first_usable_next;
    logic [bap_pkg::FRAME_W-1:0]     base_frame_reg, base_frame_next;

    logic [AW-1:0]                   ram_raddr;
    logic [bap_pkg::WORD_W-1:0]      ram_rdata;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [bap_pkg::WORD_W-1:0]      ram_wdata;

    logic [bap_pkg::CNT_W-1:0]       size;
    logic [bap_pkg::ABS_W-1:0]       carve_lim;
    logic [bap_pkg::ABS_W-1:0]       carve_start;
    bap_pkg::carve_step_t            step;
    logic [bap_pkg::ABS_W-1:0]       carve_off;
    logic [bap_pkg::WORD_W-1:0]      wr_mask;
    logic                            bit_set;
    logic                            found;
    logic [bap_pkg::ORD_W-1:0]       found_j;
    logic [bap_pkg::BIT_W-1:0]       low_bit;
    logic [bap_pkg::FRAME_W:0]       free_diff;
    logic [bap_pkg::ABS_W-1:0]       free_end;
    logic                            too_big;
    logic [PW-1:0]                   found_page;
    logic [PW-1:0]                   split_page;

    function automatic logic [bap_pkg::CNT_W-1:0] sat_add(
        input logic [bap_pkg::CNT_W-1:0] t,
        input logic [16:0]               n
    );
        logic [17:0] s;
        s = {7'b0, t} + {1'b0, n};
        return (s > 18'd2047) ? '1 : s[bap_pkg::CNT_W-1:0];
    endfunction

    function automatic logic [bap_pkg::CNT_W-1:0] floor_sub(
        input logic [bap_pkg::CNT_W-1:0] t,
        input logic [16:0]               n
    );
        logic [16:0] w;
        w = {6'b0, t};
        return (w >= n) ? bap_pkg::CNT_W'(w - n) : '0;
    endfunction

    bap_mark_ram #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    bap_carve_step #(
        .MAX_ORDER (MAX_ORDER)
    ) u_carve (
        .cur  (cur_reg),
        .lim  (carve_lim),
        .step (step)
    );

    assign size = (32'(page_count_reg) > 32'(PAGES)) ? bap_pkg::CNT_W'(PAGES)
                                                     : page_count_reg;
    assign carve_lim   = bap_pkg::ABS_W'(base_frame_reg) + bap_pkg::ABS_W'(size);
    assign carve_start = bap_pkg::ABS_W'(base_frame_reg) + bap_pkg::ABS_W'(first_usable_reg);
    assign carve_off   = cur_reg - bap_pkg::ABS_W'(base_frame_reg);
    assign wr_mask     = bap_pkg::WORD_W'(1) << wr_page_reg[bap_pkg::BIT_W-1:0];
    assign bit_set     = |(ram_rdata & wr_mask);
    assign too_big     = {1'b0, ord_reg} >= 5'(MAX_ORDER);
    assign free_diff   = {1'b0, fin_reg} - {1'b0, base_frame_reg};
    assign free_end    = {2'b0, free_diff[bap_pkg::FRAME_W-1:0]}
                       + (bap_pkg::ABS_W'(1) << ord_reg);
    assign found_page  = {row_reg, low_bit};
    assign split_page  = wr_page_reg + (PW'(1) << j_reg);

    always_comb
    begin
        found   = 1'b0;
        found_j = '0;
        for (int i = MAX_ORDER - 1; i >= 0; i--)
        begin
            if (i >= int'(ord_reg) && cnt_reg[i] != '0)
            begin
                found   = 1'b1;
                found_j = bap_pkg::ORD_W'(i);
            end
        end
    end

    always_comb
    begin
        low_bit = '0;
        for (int i = bap_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (ram_rdata[i])
            begin
                low_bit = bap_pkg::BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        act_next          = act_reg;
        ord_next          = ord_reg;
        fin_next          = fin_reg;
        j_next            = j_reg;
        row_next          = row_reg;
        wr_page_next      = wr_page_reg;
        cur_next          = cur_reg;
        sweep_next        = sweep_reg;
        carve_after_next  = carve_after_reg;
        st_next           = st_reg;
        fo_next           = fo_reg;
        total_next        = total_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        frame_out_next    = frame_out_reg;
        free_pages_next   = free_pages_reg;
        page_count_next   = page_count_reg;
        first_usable_next = first_usable_reg;
        base_frame_next   = base_frame_reg;
        ram_raddr         = addr_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = ram_rdata | wr_mask;

        if (cfg_we)
        begin
            case (cfg_index)
                bap_pkg::CFG_PAGE_COUNT:   page_count_next   = cfg_data[bap_pkg::CNT_W-1:0];
                bap_pkg::CFG_FIRST_USABLE: first_usable_next = cfg_data[bap_pkg::CNT_W-1:0];
                bap_pkg::CFG_BASE_FRAME:   base_frame_next   = cfg_data;
                default:                   ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    ord_next   = order;
                    fin_next   = frame_in;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                st_next    = bap_pkg::ST_OK;
                fo_next    = '0;
                state_next = S_FIN;
                case (act_reg)
                    bap_pkg::ACT_INIT:
                    begin
                        for (int i = 0; i < MAX_ORDER; i++)
                        begin
                            cnt_next[i] = '0;
                        end
                        total_next       = '0;
                        sweep_next       = '0;
                        carve_after_next = 1'b1;
                        cur_next         = carve_start;
                        state_next       = S_CLEAR;
                    end
                    bap_pkg::ACT_ALLOC:
                    begin
                        if (too_big)
                        begin
                            st_next = bap_pkg::ST_TOO_BIG;
                        end
                        else if (!found)
                        begin
                            st_next = bap_pkg::ST_NO_FREE;
                        end
                        else
                        begin
                            j_next     = found_j;
                            row_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    bap_pkg::ACT_FREE:
                    begin
                        if (too_big)
                        begin
                            st_next = bap_pkg::ST_TOO_BIG;
                        end
                        else if (free_diff[bap_pkg::FRAME_W] ||
                                 free_end > bap_pkg::ABS_W'(size))
                        begin
                            st_next = bap_pkg::ST_OUTSIDE;
                        end
                        else
                        begin
                            wr_page_next = free_diff[PW-1:0];
                            state_next   = S_FREE_RD;
                        end
                    end
                    default: ;
                endcase
            end

            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    carve_after_next = 1'b0;
                    state_next       = carve_after_reg ? S_CARVE_RD : S_IDLE;
                end
            end

            S_CARVE_RD:
            begin
                if (!step.fit)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr    = {step.k[OW-1:0], carve_off[PW-1:bap_pkg::BIT_W]};
                    wr_page_next = carve_off[PW-1:0];
                    j_next       = step.k;
                    state_next   = S_CARVE_WR;
                end
            end

            S_CARVE_WR:
            begin
                ram_we = 1'b1;
                if (!bit_set)
                begin
                    cnt_next[j_reg[OW-1:0]] = cnt_reg[j_reg[OW-1:0]] + bap_pkg::CNT_W'(1);
                    total_next = sat_add(total_reg, 17'(1) << j_reg);
                end
                cur_next   = cur_reg + (bap_pkg::ABS_W'(1) << j_reg);
                state_next = S_CARVE_RD;
            end

            S_SCAN_RD:
            begin
                ram_raddr  = {j_reg[OW-1:0], row_reg};
                state_next = S_SCAN_CK;
            end

            S_SCAN_CK:
            begin
                if (ram_rdata == '0)
                begin
                    row_next   = row_reg + RW'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    // take the lowest block of this order and drop its mark
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata & ~(bap_pkg::WORD_W'(1) << low_bit);
                    cnt_next[j_reg[OW-1:0]] = cnt_reg[j_reg[OW-1:0]] - bap_pkg::CNT_W'(1);
                    total_next   = floor_sub(total_reg, 17'(1) << ord_reg);
                    fo_next      = base_frame_reg + bap_pkg::FRAME_W'(found_page);
                    wr_page_next = found_page;
                    if (j_reg > ord_reg)
                    begin
                        j_next     = j_reg - bap_pkg::ORD_W'(1);
                        state_next = S_SPLIT_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_SPLIT_RD:
            begin
                // upper half of the block being split becomes free at this order
                ram_raddr    = {j_reg[OW-1:0], split_page[PW-1:bap_pkg::BIT_W]};
                wr_page_next = split_page;
                state_next   = S_SPLIT_WR;
            end

            S_SPLIT_WR:
            begin
                ram_we = 1'b1;
                if (!bit_set)
                begin
                    cnt_next[j_reg[OW-1:0]] = cnt_reg[j_reg[OW-1:0]] + bap_pkg::CNT_W'(1);
                end
                // return to the allocated page for the next split
                wr_page_next = fo_reg[PW-1:0] - base_frame_reg[PW-1:0];
                if (j_reg > ord_reg)
                begin
                    j_next     = j_reg - bap_pkg::ORD_W'(1);
                    state_next = S_SPLIT_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FREE_RD:
            begin
                ram_raddr  = {ord_reg[OW-1:0], wr_page_reg[PW-1:bap_pkg::BIT_W]};
                j_next     = ord_reg;
                // reuse the set path, then finish since j already equals the order
                state_next = S_SPLIT_WR;
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = st_reg;
                    frame_out_next  = fo_reg;
                    free_pages_next = total_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // a free adds its pages only when the mark was clear
        if (state_reg == S_SPLIT_WR && act_reg == bap_pkg::ACT_FREE && !bit_set)
        begin
            total_next = sat_add(total_reg, 17'(1) << ord_reg);
        end
        if (state_reg == S_SPLIT_WR && act_reg == bap_pkg::ACT_FREE)
        begin
            wr_page_next = wr_page_reg;
        end

        addr_next = ram_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            sweep_reg        <= '0;
            carve_after_reg  <= 1'b0;
            total_reg        <= '0;
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                cnt_reg[i] <= '0;
            end
            out_valid_reg    <= 1'b0;
            page_count_reg   <= bap_pkg::PAGE_COUNT_RST;
            first_usable_reg <= '0;
            base_frame_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            carve_after_reg  <= carve_after_next;
            total_reg        <= total_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            page_count_reg   <= page_count_next;
            first_usable_reg <= first_usable_next;
            base_frame_reg   <= base_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        ord_reg        <= ord_next;
        fin_reg        <= fin_next;
        j_reg          <= j_next;
        row_reg        <= row_next;
        wr_page_reg    <= wr_page_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        st_reg         <= st_next;
        fo_reg         <= fo_next;
        status_reg     <= status_next;
        frame_out_reg  <= frame_out_next;
        free_pages_reg <= free_pages_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign frame_out  = frame_out_reg;
    assign free_pages = free_pages_reg;

endmodule

`default_nettype wire

// ===== bench/alloc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the buddy page allocator: watches the config, request and result channels.
// Predicts each result from its own copy of the free marks; depends on bap_pkg.
module alloc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [bap_pkg::ACT_W-1:0]     action,
    input  wire logic [bap_pkg::ORD_W-1:0]     order,
    input  wire logic [bap_pkg::FRAME_W-1:0]   frame_in,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [bap_pkg::ST_W-1:0]      status,
    input  wire logic [bap_pkg::FRAME_W-1:0]   frame_out,
    input  wire logic [bap_pkg::CNT_W-1:0]     free_pages,
    input  wire logic                          cfg_we,
    input  wire logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bap_pkg::FRAME_W-1:0]   cfg_data,
    output int                                 mismatches,
    output int                                 pending
);

    localparam int NPAGES = 1024;
    localparam int NORD   = 11;

    typedef struct packed {
        logic [bap_pkg::ST_W-1:0]    st;
        logic [bap_pkg::FRAME_W-1:0] frm;
        logic [bap_pkg::CNT_W-1:0]   pages;
    } alloc_result_t;

    bit          marks [NORD][NPAGES];
    int          page_total;
    int          pg_count;
    int          first_usable;
    longint      base;

    alloc_result_t expected_results [$];

    function automatic int region_pages();
        return (pg_count > NPAGES) ? NPAGES : pg_count;
    endfunction

    function automatic void add_pages(int n);
        page_total = (page_total + n > 2047) ? 2047 : page_total + n;
    endfunction

    function automatic void set_mark(int k, int p);
        marks[k][p] = 1'b1;
    endfunction

    function automatic void clear_mark(int k, int p);
        marks[k][p] = 1'b0;
    endfunction

    function automatic void wipe_marks();
        for (int k = 0; k < NORD; k++)
        begin
            for (int p = 0; p < NPAGES; p++)
                marks[k][p] = 1'b0;
        end
        page_total = 0;
    endfunction

    function automatic void carve_region();
        longint size;
        longint start;
        longint span;
        longint idx;
        longint skip;
        size  = region_pages();
        start = base + first_usable;
        wipe_marks();
        for (int k = NORD - 1; k >= 0; k--)
        begin
            span = longint'(1) << k;
            idx  = ((start + span - 1) & ~(span - 1)) - base;
            while (idx < size && size - idx >= span)
            begin
                skip = 0;
                for (int j = NORD - 1; j > k; j--)
                begin
                    if (skip == 0 && marks[j][idx])
                        skip = longint'(1) << j;
                end
                if (skip != 0)
                    idx += skip;
                else
                begin
                    set_mark(k, int'(idx));
                    add_pages(int'(span));
                    idx += span;
                end
            end
        end
    endfunction

    function automatic alloc_result_t predict_step(logic [bap_pkg::ACT_W-1:0] act,
                                                   logic [bap_pkg::ORD_W-1:0] ord,
                                                   logic [bap_pkg::FRAME_W-1:0] frm);
        alloc_result_t r;
        int            j;
        int            pg;
        bit            found;
        int            need;
        longint        f;
        r.st  = bap_pkg::ST_OK;
        r.frm = '0;
        f     = frm;
        if (act == bap_pkg::ACT_INIT)
            carve_region();
        else if (act == bap_pkg::ACT_ALLOC)
        begin
            if (ord >= NORD)
                r.st = bap_pkg::ST_TOO_BIG;
            else
            begin
                found = 0;
                pg    = 0;
                for (j = ord; j < NORD && !found; j++)
                begin
                    for (int p = 0; p < NPAGES && !found; p++)
                    begin
                        if (marks[j][p])
                        begin
                            found = 1;
                            pg    = p;
                        end
                    end
                    if (found)
                        break;
                end
                if (!found)
                    r.st = bap_pkg::ST_NO_FREE;
                else
                begin
                    need = 1 << ord;
                    clear_mark(j, pg);
                    // hand back the upper halves as we split down
                    while (j > ord)
                    begin
                        j--;
                        set_mark(j, pg + (1 << j));
                    end
                    page_total = (page_total >= need) ? page_total - need : 0;
                    r.frm = bap_pkg::FRAME_W'(base + pg);
                end
            end
        end
        else if (act == bap_pkg::ACT_FREE)
        begin
            if (ord >= NORD)
                r.st = bap_pkg::ST_TOO_BIG;
            else if (f < base || f - base + (longint'(1) << ord) > region_pages())
                r.st = bap_pkg::ST_OUTSIDE;
            else if (!marks[ord][int'(f - base)])
            begin
                set_mark(ord, int'(f - base));
                add_pages(1 << ord);
            end
        end
        r.pages = bap_pkg::CNT_W'(page_total);
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (!rst_n)
        begin
            mismatches   = 0;
            pg_count     = 1024;
            first_usable = 0;
            base         = 0;
            wipe_marks();
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == bap_pkg::CFG_PAGE_COUNT)
                    pg_count = int'(cfg_data[bap_pkg::CNT_W-1:0]);
                else if (cfg_index == bap_pkg::CFG_FIRST_USABLE)
                    first_usable = int'(cfg_data[bap_pkg::CNT_W-1:0]);
                else if (cfg_index == bap_pkg::CFG_BASE_FRAME)
                    base = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.st, status);
                        mismatches++;
                    end
                    if (frame_out !== exp_r.frm)
                    begin
                        $error("frame_out: expected %0h, got %0h", exp_r.frm, frame_out);
                        mismatches++;
                    end
                    if (free_pages !== exp_r.pages)
                    begin
                        $error("free_pages: expected %0d, got %0d", exp_r.pages, free_pages);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_step(action, order, frame_in));
        end
        pending = expected_results.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Top of the allocator bench: clock, reset, request and config stimulus, verdict.
// Depends on bap_pkg, buddy_page_allocator and alloc_checker.
module tb;

    localparam int RUN_LIMIT = 3000000;
    localparam int NRAND     = 1530;
    localparam int NCFG      = 6;

    // action code with no meaning; the block must ignore it
    localparam logic [bap_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [bap_pkg::ACT_W-1:0]       action = bap_pkg::ACT_INIT;
    logic [bap_pkg::ORD_W-1:0]       order = '0;
    logic [bap_pkg::FRAME_W-1:0]     frame_in = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [bap_pkg::ST_W-1:0]        status;
    logic [bap_pkg::FRAME_W-1:0]     frame_out;
    logic [bap_pkg::CNT_W-1:0]       free_pages;
    logic                            cfg_we = 1'b0;
    logic [bap_pkg::CFG_IDX_W-1:0]   cfg_index = bap_pkg::CFG_PAGE_COUNT;
    logic [bap_pkg::FRAME_W-1:0]     cfg_data = '0;
    int                              mismatches;
    int                              pending;
    int                              cycles = 0;
    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              cur_pages = 1024;
    int                              cur_base = 0;
    int                              beats_sent = 0;

    always #2 clk = ~clk;

    buddy_page_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .order(order), .frame_in(frame_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .frame_out(frame_out), .free_pages(free_pages),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    alloc_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .order(order), .frame_in(frame_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .frame_out(frame_out), .free_pages(free_pages),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycles >= RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic [bap_pkg::ACT_W-1:0] a, logic [bap_pkg::ORD_W-1:0] o,
                             logic [bap_pkg::FRAME_W-1:0] f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        order    <= o;
        frame_in <= f;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // drop valid, let every result land, then give the block time to settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(int pc, int fu, int bf);
        cfg_we    <= 1'b1;
        cfg_index <= bap_pkg::CFG_PAGE_COUNT;
        cfg_data  <= bap_pkg::FRAME_W'(pc);
        @(posedge clk);
        cfg_index <= bap_pkg::CFG_FIRST_USABLE;
        cfg_data  <= bap_pkg::FRAME_W'(fu);
        @(posedge clk);
        cfg_index <= bap_pkg::CFG_BASE_FRAME;
        cfg_data  <= bap_pkg::FRAME_W'(bf);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_pages = (pc % 2048 > 1024) ? 1024 : pc % 2048;
        cur_base  = bf;
    endtask

    task automatic random_beat();
        int r;
        int o;
        int pg;
        r = $urandom_range(99);
        if (r < 2)
            send_beat(bap_pkg::ACT_INIT, bap_pkg::ORD_W'($urandom),
                      bap_pkg::FRAME_W'($urandom));
        else if (r < 48)
        begin
            o = ($urandom_range(99) < 80) ? $urandom_range(0, 4) :
                ($urandom_range(99) < 80) ? $urandom_range(5, 10) : $urandom_range(11, 15);
            send_beat(bap_pkg::ACT_ALLOC, bap_pkg::ORD_W'(o), bap_pkg::FRAME_W'($urandom));
        end
        else if (r < 88)
        begin
            o = $urandom_range(0, 6);
            if (cur_pages >= (1 << o))
                pg = $urandom_range(0, cur_pages - (1 << o)) & ~((1 << o) - 1);
            else
                pg = 0;
            send_beat(bap_pkg::ACT_FREE, bap_pkg::ORD_W'(o), bap_pkg::FRAME_W'(cur_base + pg));
        end
        else if (r < 96)
            send_beat(bap_pkg::ACT_FREE, bap_pkg::ORD_W'($urandom),
                      bap_pkg::FRAME_W'($urandom));
        else
            send_beat(ACT_UNUSED, bap_pkg::ORD_W'($urandom), bap_pkg::FRAME_W'($urandom));
    endtask

    initial
    begin
        int pc_set [NCFG];
        int fu_set [NCFG];
        int bf_set [NCFG];
        int per_phase;
        pc_set    = '{1024, 1000, 0, 2047, 37, 1024};
        fu_set    = '{0, 3, 0, 1024, 5, 2047};
        bf_set    = '{0, 'h12345, 'hFFFFF, 'hFFFFF, 1000, 'h00400};
        per_phase = NRAND / NCFG;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults after reset
        send_beat(bap_pkg::ACT_ALLOC, 4'd0, '0);       // nothing carved yet
        send_beat(bap_pkg::ACT_INIT, 4'd0, '0);
        send_beat(bap_pkg::ACT_ALLOC, 4'd0, '0);       // splits the whole region
        send_beat(bap_pkg::ACT_ALLOC, 4'd9, '0);
        send_beat(bap_pkg::ACT_ALLOC, 4'd10, '0);      // nothing that large left
        send_beat(bap_pkg::ACT_ALLOC, 4'd11, '0);
        send_beat(bap_pkg::ACT_ALLOC, 4'd15, '0);
        send_beat(bap_pkg::ACT_FREE, 4'd12, '0);
        send_beat(bap_pkg::ACT_FREE, 4'd1, 20'd1023);  // runs past the region end
        send_beat(bap_pkg::ACT_FREE, 4'd0, 20'hFFFFF);
        send_beat(bap_pkg::ACT_FREE, 4'd0, 20'd0);
        send_beat(bap_pkg::ACT_FREE, 4'd0, 20'd0);     // already free
        send_beat(ACT_UNUSED, 4'hF, 20'hFFFFF);
        send_beat(bap_pkg::ACT_INIT, 4'd0, '0);        // repeated init
        for (int k = 9; k >= 0; k--)
            send_beat(bap_pkg::ACT_FREE, bap_pkg::ORD_W'(k), '0); // overlaps saturate the total
        send_beat(bap_pkg::ACT_ALLOC, 4'd10, '0);
        send_beat(bap_pkg::ACT_ALLOC, 4'd10, '0);
        // hold off until every result is back
        drain();

        for (int c = 0; c < NCFG; c++)
        begin
            write_cfg(pc_set[c], fu_set[c], bf_set[c]);
            send_beat(bap_pkg::ACT_INIT, 4'd0, '0);
            if (c == 1)
                send_beat(bap_pkg::ACT_FREE, 4'd0, 20'h12344); // below the base
            for (int i = 0; i < per_phase; i++)
            begin
                if (c * per_phase + i < NRAND / 3)
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 58;
                end
                else if (c * per_phase + i < 2 * NRAND / 3)
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 30;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_beat();
            end
            drain();
        end

        $display("Covered %0d request beats over %0d region settings with init, alloc and free",
                 beats_sent, NCFG + 1);
        $display("under sender and receiver idling in both ratios and without idling.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
